// ===== sv/owp_pkg.sv =====
// ----------------------------------------------------------------------------
// owp_pkg
// Shared types, constants and helper functions for the one-wire temperature
// probe master.
// ----------------------------------------------------------------------------
package owp_pkg;

   // Bus timing, in one-microsecond ticks.
   localparam int unsigned COMMAND_BITS   = 16;
   localparam int unsigned CONVERT_PERIOD = 1000000;
   localparam int unsigned READ_SAMPLES   = 16;

   localparam int TICK_W  = $clog2(CONVERT_PERIOD + 2);
   localparam int SLOT_MAX = (COMMAND_BITS > READ_SAMPLES) ? COMMAND_BITS : READ_SAMPLES;
   localparam int SLOT_W  = $clog2(SLOT_MAX + 1);

   localparam int CMD_W   = 16;
   localparam int SHIFT_W = 16;
   localparam int TEMP_W  = 14;
   localparam int PHASE_W = 3;
   localparam int KIND_W  = 2;

   localparam logic [TICK_W-1:0] RESET_PERIOD   = TICK_W'(1001);
   localparam logic [TICK_W-1:0] RESET_RELEASE  = TICK_W'(500);
   localparam logic [TICK_W-1:0] RESET_SAMPLE   = TICK_W'(575);
   localparam logic [TICK_W-1:0] SLOT_PERIOD    = TICK_W'(101);
   localparam logic [TICK_W-1:0] SLOT_RELEASE   = TICK_W'(1);
   localparam logic [TICK_W-1:0] WRITE_RELEASE  = TICK_W'(60);
   localparam logic [TICK_W-1:0] READ_SAMPLE_AT = TICK_W'(15);
   localparam logic [TICK_W-1:0] WAIT_PERIOD    = TICK_W'(CONVERT_PERIOD + 1);

   localparam logic [CMD_W-1:0] CONVERT_COMMAND_RESET = CMD_W'(17612);
   localparam logic [CMD_W-1:0] READ_COMMAND_RESET    = CMD_W'(48844);

   // Sequencer phases, one-hot.
   typedef enum logic [6:0] {
      PH_IDLE       = 7'b0000001,
      PH_CONV_RESET = 7'b0000010,
      PH_CONV_WRITE = 7'b0000100,
      PH_CONVERT    = 7'b0001000,
      PH_READ_RESET = 7'b0010000,
      PH_READ_WRITE = 7'b0100000,
      PH_READ       = 7'b1000000
   } phase_type;

   // Reported phase numbers.
   localparam logic [PHASE_W-1:0] CODE_IDLE       = 3'd0;
   localparam logic [PHASE_W-1:0] CODE_CONV_RESET = 3'd1;
   localparam logic [PHASE_W-1:0] CODE_CONV_WRITE = 3'd2;
   localparam logic [PHASE_W-1:0] CODE_CONVERT    = 3'd3;
   localparam logic [PHASE_W-1:0] CODE_READ_RESET = 3'd4;
   localparam logic [PHASE_W-1:0] CODE_READ_WRITE = 3'd5;
   localparam logic [PHASE_W-1:0] CODE_READ       = 3'd6;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      CSR_CONVERT_COMMAND = 1'b0,
      CSR_READ_COMMAND    = 1'b1
   } csr_index_type;

   typedef struct packed {
      phase_type          phase;
      logic [TICK_W-1:0]  tick;
      logic [SHIFT_W-1:0] out_shift;
      logic [SLOT_W-1:0]  slot;
      logic [SHIFT_W-1:0] in_shift;
      logic               presence;
      logic               wait_skipped;
      logic [TEMP_W-1:0]  temperature;
      logic               line_level;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:        PH_IDLE,
      tick:         '0,
      out_shift:    '0,
      slot:         '0,
      in_shift:     '0,
      presence:     1'b0,
      wait_skipped: 1'b0,
      temperature:  '0,
      line_level:   1'b1
   };

   typedef struct packed {
      logic               line_release;
      logic               connected;
      logic [TEMP_W-1:0]  temperature;
      logic [PHASE_W-1:0] phase;
   } result_type;

   // Length of one period of a phase.
   function automatic logic [TICK_W-1:0] owp_period(input phase_type ph);
      logic [TICK_W-1:0] p;
      case (ph)
         PH_CONV_RESET, PH_READ_RESET: p = RESET_PERIOD;
         PH_CONVERT:                   p = WAIT_PERIOD;
         default:                      p = SLOT_PERIOD;
      endcase
      return p;
   endfunction

   function automatic logic [PHASE_W-1:0] owp_phase_code(input phase_type ph);
      logic [PHASE_W-1:0] c;
      case (ph)
         PH_CONV_RESET: c = CODE_CONV_RESET;
         PH_CONV_WRITE: c = CODE_CONV_WRITE;
         PH_CONVERT:    c = CODE_CONVERT;
         PH_READ_RESET: c = CODE_READ_RESET;
         PH_READ_WRITE: c = CODE_READ_WRITE;
         PH_READ:       c = CODE_READ;
         default:       c = CODE_IDLE;
      endcase
      return c;
   endfunction

   // Raw reading in sixteenths of a degree to hundredths: raw * 25 / 4.
   function automatic logic [TEMP_W-1:0] owp_decode_temp(input logic [10:0] raw);
      logic [15:0] prod;
      prod = {1'b0, raw, 4'b0000} + {2'b00, raw, 3'b000} + {5'b00000, raw};
      return prod[15:2];
   endfunction

endpackage

// ===== sv/one_wire_temp_probe_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_temp_probe_master
// One-wire bus master that drives a temperature probe through reset, convert,
// and scratchpad read sequences, advanced by one-microsecond tick
// transactions.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+------------------------------------
//   req_    | in        | req_valid/stall    | kind, line_sample
//   rsp_    | out       | rsp_valid/stall    | line_release, connected,
//           |           |                    | temperature_centi, phase
//   csr_    | in        | csr_write_enable   | csr_index, csr_write_data
//
// Every accepted request transaction produces exactly one response
// transaction in the next cycle; a new request can be taken each unstalled cycle.
// The sequencer state is updated in the cycle a request is accepted, and the
// result is held in the response register until it is taken.
// req_stall is raised only while the response register is full and stalled.
// The synchronous reset returns the sequencer to idle with the line
// released and loads the default command words.
// ----------------------------------------------------------------------------
module one_wire_temp_probe_master
   import owp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic               req_line_sample,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_line_release,
   output logic               rsp_connected,
   output logic [TEMP_W-1:0]  rsp_temperature_centi,
   output logic [PHASE_W-1:0] rsp_phase,

   input  logic               csr_write_enable,
   input  logic [0:0]         csr_index,
   input  logic [CMD_W-1:0]   csr_write_data
);

   // Command words that are shifted out during the two write phases.
   logic [CMD_W-1:0] convert_command_ff;
   logic [CMD_W-1:0] read_command_ff;

   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_out;
   logic       req_accept;

   // The request side waits only when the held result has not been taken.
   assign req_stall  = rsp_valid & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         convert_command_ff <= CONVERT_COMMAND_RESET;
         read_command_ff    <= READ_COMMAND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_CONVERT_COMMAND: convert_command_ff <= csr_write_data;
            CSR_READ_COMMAND:    read_command_ff    <= csr_write_data;
            default: begin
               convert_command_ff <= convert_command_ff;
            end
         endcase
      end
   end

   // All per-transaction work is the next-state logic below.
   owp_step u_step (
      .cur             (state_ff),
      .kind            (req_kind),
      .line_sample     (req_line_sample),
      .convert_command (convert_command_ff),
      .read_command    (read_command_ff),
      .nxt             (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // The response reports the state after this transaction is applied.
   assign result_in.line_release = state_in.line_level;
   assign result_in.connected    = state_in.presence;
   assign result_in.temperature  = state_in.temperature;
   assign result_in.phase        = owp_phase_code(state_in.phase);

   owp_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .result_in  (result_in),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .result_out (result_out)
   );

   assign rsp_line_release      = result_out.line_release;
   assign rsp_connected         = result_out.connected;
   assign rsp_temperature_centi = result_out.temperature;
   assign rsp_phase             = result_out.phase;

   // An idle tick must leave the whole sequencer untouched.
   a_idle_tick_holds: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (state_ff.phase == PH_IDLE) && (req_kind == KIND_TICK))
      |=> (state_ff == $past(state_ff)))
      else $error("idle tick changed sequencer state");

   // The phase counter always stays inside the current phase's period.
   a_tick_in_period: assert property (@(posedge clock) disable iff (reset)
      state_ff.tick < owp_period(state_ff.phase))
      else $error("tick counter beyond phase period");

   // The decoded temperature only changes on entry to the conversion wait.
   a_temp_on_convert: assert property (@(posedge clock) disable iff (reset)
      (state_ff.temperature != $past(state_ff.temperature))
      |-> (state_ff.phase == PH_CONVERT))
      else $error("temperature changed outside conversion entry");

endmodule

// ===== sv/owp_step.sv =====
// ----------------------------------------------------------------------------
// owp_step
// Next-state logic of the bus sequencer for one transaction (tick, start or
// stop).
// ----------------------------------------------------------------------------
module owp_step
   import owp_pkg::*;
(
   input  state_type        cur,
   input  logic [KIND_W-1:0] kind,
   input  logic             line_sample,
   input  logic [CMD_W-1:0] convert_command,
   input  logic [CMD_W-1:0] read_command,
   output state_type        nxt
);

   logic [TICK_W-1:0]  t;
   logic               update;
   logic [SHIFT_W-1:0] wait_shift;

   assign t          = cur.tick + TICK_W'(1);
   assign update     = (t >= owp_period(cur.phase));
   assign wait_shift = {1'b0, cur.in_shift[SHIFT_W-1:1]};

   always_comb begin
      nxt = cur;
      case (kind_type'(kind))
         KIND_TICK: begin
            if (cur.phase != PH_IDLE) begin
               nxt.tick = update ? '0 : t;
            end
            case (cur.phase)
               PH_CONV_RESET, PH_READ_RESET: begin
                  if (update) begin
                     nxt.tick = '0;
                     if (!cur.presence) begin
                        nxt.phase      = PH_CONV_RESET;
                        nxt.line_level = 1'b0;
                     end else if (cur.phase == PH_CONV_RESET) begin
                        nxt.phase     = PH_CONV_WRITE;
                        nxt.slot      = '0;
                        nxt.out_shift = convert_command;
                     end else begin
                        nxt.phase     = PH_READ_WRITE;
                        nxt.slot      = '0;
                        nxt.out_shift = read_command;
                     end
                  end else if (t == RESET_RELEASE) begin
                     nxt.line_level = 1'b1;
                  end else if (t == RESET_SAMPLE) begin
                     nxt.presence = ~line_sample;
                  end
               end
               PH_CONV_WRITE, PH_READ_WRITE: begin
                  if (update) begin
                     if (cur.slot != SLOT_W'(COMMAND_BITS)) begin
                        nxt.line_level = 1'b0;
                        nxt.slot       = cur.slot + SLOT_W'(1);
                     end else if (cur.phase == PH_CONV_WRITE) begin
                        nxt.phase        = PH_CONVERT;
                        nxt.wait_skipped = 1'b0;
                        nxt.in_shift     = wait_shift;
                        nxt.temperature  = owp_decode_temp(wait_shift[10:0]);
                     end else begin
                        nxt.phase    = PH_READ;
                        nxt.slot     = '0;
                        nxt.in_shift = '0;
                     end
                  end else if (t == SLOT_RELEASE) begin
                     if ((cur.slot != '0) && cur.out_shift[0]) begin
                        nxt.line_level = 1'b1;
                     end
                  end else if (t == WRITE_RELEASE) begin
                     nxt.line_level = 1'b1;
                     if (cur.slot != '0) begin
                        nxt.out_shift = {1'b0, cur.out_shift[SHIFT_W-1:1]};
                     end
                  end
               end
               PH_CONVERT: begin
                  if (update) begin
                     if (cur.wait_skipped) begin
                        nxt.phase      = PH_READ_RESET;
                        nxt.line_level = 1'b0;
                     end else begin
                        nxt.wait_skipped = 1'b1;
                     end
                  end
               end
               PH_READ: begin
                  if (update) begin
                     nxt.line_level = 1'b0;
                     if (cur.slot == SLOT_W'(READ_SAMPLES)) begin
                        nxt.phase = PH_CONV_RESET;
                     end
                  end else if (t == SLOT_RELEASE) begin
                     nxt.line_level = 1'b1;
                  end else if (t == READ_SAMPLE_AT) begin
                     nxt.in_shift = {line_sample, cur.in_shift[SHIFT_W-1:1]};
                     nxt.slot     = cur.slot + SLOT_W'(1);
                  end
               end
               default: begin
                  nxt.tick = cur.tick;
               end
            endcase
         end
         KIND_START: begin
            nxt.phase      = PH_CONV_RESET;
            nxt.tick       = '0;
            nxt.line_level = 1'b0;
         end
         KIND_STOP: begin
            nxt.phase = PH_IDLE;
            nxt.tick  = '0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== sv/owp_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// owp_rsp_reg
// Result register of the response channel with its valid flag.
// ----------------------------------------------------------------------------
module owp_rsp_reg
   import owp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result_in,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type result_out
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign result_out = data_ff;

   // A loaded result must be offered in the following cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

endmodule
